// ===== rtl/core/sobel_edge_threshold_3x3_defines.svh =====
// Assertion helpers, sampled on clk and disabled while arst_n is low.
`ifndef SOBEL_EDGE_THRESHOLD_3X3_DEFINES_SVH
`define SOBEL_EDGE_THRESHOLD_3X3_DEFINES_SVH

// same-cycle implication
`define SOBEL_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SOBEL_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/sobel_pkg.sv =====
package sobel_pkg;

	parameter int MAX_WIDTH_DEF  = 1024;
	parameter int MAX_HEIGHT_DEF = 1024;

	parameter int WIN      = 3;
	parameter int SMOOTH_W = 10;
	parameter int DIFF_W   = 9;
	parameter int GRAD_W   = 11;
	parameter int MAG_W    = 21;
	parameter int LIM_W    = 24;

	parameter logic [10:0] WIDTH_RST  = 11'd640;
	parameter logic [10:0] HEIGHT_RST = 11'd480;
	parameter logic [9:0]  THRESH_RST = 10'd50;
	parameter logic [23:0] LIM_RST    = 24'(16 * 50 * 50);

	parameter logic [7:0] PIX_MAX = 8'd255;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_THRESH = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_t;

	// one window column, top to bottom
	typedef struct packed {
		pix_t up;
		pix_t mid;
		pix_t cur;
	} col_t;

	// one line store entry: both stored rows at a column
	typedef struct packed {
		pix_t upper;
		pix_t middle;
	} line_t;

	typedef struct packed {
		logic emit;
		logic inner;
		logic last;
	} tag_t;

endpackage

// ===== rtl/core/sobel_edge_threshold_3x3.sv =====
// Streaming 3x3 Sobel edge marker on RGB pixels in raster order.
// Input channel (in_valid/in_ready): op, in_red, in_green, in_blue. op = 1 is a
// flush word that pushes the last row out; a flush at the very start of a frame
// is swallowed. Output channel (out_valid/out_ready): out_red, out_green,
// out_blue, frame_done. Interior pixels come out black or white, border pixels
// keep their color; frame_done marks the last pixel of a frame.
// Config channel (cfg_valid/cfg_ready, always ready): cfg_index selects
// width, height or threshold, cfg_data is the value; write only while idle.
// Throughput: one word per clock while out_ready does not hold the pipeline,
// set by the single read port of the line store. The output for pixel n comes
// from input word n + width + 1 through the line store read at acceptance,
// then window shift, gradient, magnitude and output register.
// When out_ready is low with a word waiting, the whole pipeline freezes and
// in_ready drops in the same cycle; nothing is lost or repeated.
// Reset: width 640, height 480, threshold 50, position counters zero. The line
// stores are not cleared; the first rows of a frame fill them before use.
`include "sobel_edge_threshold_3x3_defines.svh"

module sobel_edge_threshold_3x3 #(
	parameter int MAX_WIDTH  = sobel_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = sobel_pkg::MAX_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [7:0]  in_red,
	input  logic [7:0]  in_green,
	input  logic [7:0]  in_blue,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic        frame_done,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int RW  = $clog2(MAX_HEIGHT + 2);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int XW  = CW + 2;
	localparam int YW  = RW + 2;
	localparam int WIN = sobel_pkg::WIN;

	logic [10:0]              width_q, height_q;
	logic [9:0]               thresh_q;
	logic [19:0]              thr_sq;
	logic [sobel_pkg::LIM_W-1:0] lim_q;
	logic [WW-1:0]            w_c;
	logic [HW-1:0]            h_c;

	logic [CW-1:0]            in_col_q, col_nx, x_c, col_s1;
	logic [RW-1:0]            in_row_q, row_nx, y_c;
	logic                     en, acc, noop, adv;
	logic                     emit_c, inner_c, last_c;
	sobel_pkg::pix_t          px_c, px_s1;
	logic                     v_s1, v_s2;
	sobel_pkg::tag_t          tag_s1, tag_s2;
	sobel_pkg::line_t         rd_line, wr_line;
	sobel_pkg::col_t          new_col;

	sobel_pkg::col_t          win_in  [WIN];
	sobel_pkg::col_t          win_col [WIN];
	logic [sobel_pkg::SMOOTH_W-1:0]      smooth [WIN];
	logic signed [sobel_pkg::DIFF_W-1:0] diff   [WIN];

	// configuration
	assign cfg_ready = 1'b1;
	assign thr_sq    = 20'(thresh_q) * 20'(thresh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= sobel_pkg::WIDTH_RST;
			height_q <= sobel_pkg::HEIGHT_RST;
			thresh_q <= sobel_pkg::THRESH_RST;
			lim_q    <= sobel_pkg::LIM_RST;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					sobel_pkg::REG_WIDTH:  width_q  <= cfg_data;
					sobel_pkg::REG_HEIGHT: height_q <= cfg_data;
					sobel_pkg::REG_THRESH: thresh_q <= cfg_data[9:0];
					default: ;
				endcase
			end
			lim_q <= {thr_sq, 4'b0000};
		end
	end

	always_comb begin
		if (width_q < 11'd3) begin
			w_c = WW'(3);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_c = WW'(MAX_WIDTH);
		end else begin
			w_c = WW'(width_q);
		end
		if (height_q < 11'd3) begin
			h_c = HW'(3);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			h_c = HW'(MAX_HEIGHT);
		end else begin
			h_c = HW'(height_q);
		end
	end

	// input position and per-word control
	assign en       = !out_valid || out_ready;
	assign in_ready = en;
	assign acc      = in_valid && en;
	assign noop     = op && in_row_q == '0 && in_col_q == '0;
	assign px_c     = op ? '0 : {in_red, in_green, in_blue};

	always_comb begin
		emit_c = (in_row_q >= RW'(2)) || (in_row_q == RW'(1) && in_col_q != '0);
		if (in_col_q != '0) begin
			y_c = in_row_q - RW'(1);
			x_c = in_col_q - CW'(1);
		end else begin
			y_c = in_row_q - RW'(2);
			x_c = CW'(w_c - WW'(1));
		end
		inner_c = y_c != '0 && YW'(y_c) + YW'(2) <= YW'(h_c)
			&& x_c != '0 && XW'(x_c) + XW'(2) <= XW'(w_c);
		last_c = emit_c && YW'(y_c) + YW'(1) >= YW'(h_c) && XW'(x_c) + XW'(1) >= XW'(w_c);
		if (XW'(in_col_q) + XW'(1) >= XW'(w_c)) begin
			col_nx = '0;
			row_nx = in_row_q + RW'(1);
		end else begin
			col_nx = in_col_q + CW'(1);
			row_nx = in_row_q;
		end
		if (last_c) begin
			col_nx = '0;
			row_nx = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q <= '0;
			in_row_q <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
		end else begin
			if (acc && !noop) begin
				in_col_q <= col_nx;
				in_row_q <= row_nx;
			end
			if (en) begin
				v_s1 <= acc && !noop;
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			tag_s1 <= '{emit: emit_c, inner: inner_c, last: last_c};
			px_s1  <= px_c;
			col_s1 <= in_col_q;
		end
		if (en) begin
			tag_s2 <= tag_s1;
		end
	end

	// line stores: middle row moves up, new pixel becomes middle
	assign adv     = v_s1 && en;
	assign wr_line = '{upper: rd_line.middle, middle: px_s1};
	assign new_col = '{up: rd_line.upper, mid: rd_line.middle, cur: px_s1};

	sobel_line #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_line (
		.clk     (clk),
		.rd_en   (acc),
		.rd_addr (in_col_q),
		.wr_en   (adv),
		.wr_addr (col_s1),
		.wr_data (wr_line),
		.rd_data (rd_line)
	);

	// window: index 0 is the left column, new columns enter on the right
	for (genvar i = 0; i < WIN; i++) begin : g_cell
		if (i == WIN - 1) begin : g_head
			assign win_in[i] = new_col;
		end else begin : g_link
			assign win_in[i] = win_col[i + 1];
		end
		sobel_cell u_cell (
			.clk     (clk),
			.load    (adv),
			.col_in  (win_in[i]),
			.col_out (win_col[i]),
			.smooth  (smooth[i]),
			.diff    (diff[i])
		);
	end

	sobel_grad u_grad (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.v_in       (v_s2),
		.tag_in     (tag_s2),
		.smooth_l   (smooth[0]),
		.smooth_r   (smooth[WIN - 1]),
		.diff_l     (diff[0]),
		.diff_c     (diff[1]),
		.diff_r     (diff[WIN - 1]),
		.center     (win_col[1].mid),
		.lim        (lim_q),
		.out_valid  (out_valid),
		.out_red    (out_red),
		.out_green  (out_green),
		.out_blue   (out_blue),
		.frame_done (frame_done)
	);

	`SOBEL_ASSERT_NEXT(a_frame_wrap, acc && !noop && last_c, in_col_q == '0 && in_row_q == '0, "position not cleared after last pixel of frame")
	`SOBEL_ASSERT_NEXT(a_idle_flush, acc && noop, !v_s1 && in_col_q == '0 && in_row_q == '0, "idle flush word entered the pipeline")

endmodule

// ===== rtl/core/sobel_line.sv =====
module sobel_line #(
	parameter int MAX_WIDTH = sobel_pkg::MAX_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          rd_en,
	input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
	input  logic                          wr_en,
	input  logic [$clog2(MAX_WIDTH)-1:0]  wr_addr,
	input  sobel_pkg::line_t              wr_data,
	output sobel_pkg::line_t              rd_data
);

	sobel_pkg::line_t mem_q [MAX_WIDTH];
	sobel_pkg::line_t rd_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			// write-through when the column is being retired in the same cycle
			if (wr_en && wr_addr == rd_addr) begin
				rd_s1 <= wr_data;
			end else begin
				rd_s1 <= mem_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_s1;

endmodule

// ===== rtl/core/sobel_cell.sv =====
module sobel_cell (
	input  logic                                  clk,
	input  logic                                  load,
	input  sobel_pkg::col_t                       col_in,
	output sobel_pkg::col_t                       col_out,
	output logic [sobel_pkg::SMOOTH_W-1:0]        smooth,
	output logic signed [sobel_pkg::DIFF_W-1:0]   diff
);

	localparam int SW = sobel_pkg::SMOOTH_W;

	sobel_pkg::col_t col_q;

	always_ff @(posedge clk) begin
		if (load) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;
	// vertical 1-2-1 and bottom minus top on blue
	assign smooth = SW'(col_q.up.blue) + {1'b0, col_q.mid.blue, 1'b0} + SW'(col_q.cur.blue);
	assign diff   = $signed({1'b0, col_q.cur.blue}) - $signed({1'b0, col_q.up.blue});

endmodule

// ===== rtl/core/sobel_grad.sv =====
`include "sobel_edge_threshold_3x3_defines.svh"

module sobel_grad (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  v_in,
	input  sobel_pkg::tag_t                       tag_in,
	input  logic [sobel_pkg::SMOOTH_W-1:0]        smooth_l,
	input  logic [sobel_pkg::SMOOTH_W-1:0]        smooth_r,
	input  logic signed [sobel_pkg::DIFF_W-1:0]   diff_l,
	input  logic signed [sobel_pkg::DIFF_W-1:0]   diff_c,
	input  logic signed [sobel_pkg::DIFF_W-1:0]   diff_r,
	input  sobel_pkg::pix_t                       center,
	input  logic [sobel_pkg::LIM_W-1:0]           lim,
	output logic                                  out_valid,
	output logic [7:0]                            out_red,
	output logic [7:0]                            out_green,
	output logic [7:0]                            out_blue,
	output logic                                  frame_done
);

	localparam int GW = sobel_pkg::GRAD_W;
	localparam int MW = sobel_pkg::MAG_W;
	localparam int LW = sobel_pkg::LIM_W;

	logic signed [GW-1:0]   dx_c, dy_c;
	logic signed [GW-1:0]   dx_s3, dy_s3;
	logic signed [2*GW-1:0] dx2, dy2;
	logic [MW-1:0]          mag_c, mag_s4;
	logic                   hit;
	logic                   v_s3, v_s4;
	sobel_pkg::tag_t        tag_s3, tag_s4;
	sobel_pkg::pix_t        ctr_s3, ctr_s4;
	logic                   out_valid_q, frame_done_q, inner_q;
	logic [7:0]             red_q, green_q, blue_q;

	assign dx_c = $signed(GW'(smooth_r)) - $signed(GW'(smooth_l));
	assign dy_c = GW'(diff_l) + (GW'(diff_c) <<< 1) + GW'(diff_r);

	assign dx2   = dx_s3 * dx_s3;
	assign dy2   = dy_s3 * dy_s3;
	assign mag_c = MW'($unsigned(dx2)) + MW'($unsigned(dy2));
	assign hit   = LW'(mag_s4) > lim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s3        <= v_in && tag_in.emit;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s3 <= tag_in;
			dx_s3  <= dx_c;
			dy_s3  <= dy_c;
			ctr_s3 <= center;
			tag_s4 <= tag_s3;
			mag_s4 <= mag_c;
			ctr_s4 <= ctr_s3;
			if (v_s4) begin
				inner_q      <= tag_s4.inner;
				frame_done_q <= tag_s4.last;
				if (tag_s4.inner) begin
					red_q   <= hit ? sobel_pkg::PIX_MAX : '0;
					green_q <= hit ? sobel_pkg::PIX_MAX : '0;
					blue_q  <= hit ? sobel_pkg::PIX_MAX : '0;
				end else begin
					red_q   <= ctr_s4.red;
					green_q <= ctr_s4.green;
					blue_q  <= ctr_s4.blue;
				end
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_red    = red_q;
	assign out_green  = green_q;
	assign out_blue   = blue_q;
	assign frame_done = frame_done_q;

	`SOBEL_ASSERT_IMPL(a_inner_bw, out_valid_q && inner_q, red_q == green_q && green_q == blue_q && (blue_q == 8'd0 || blue_q == 8'd255), "interior word not pure black or white")
	`SOBEL_ASSERT_NEXT(a_out_load, en && v_s4, out_valid_q, "finished pixel lost before output register")

endmodule
